[sv/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mfwt_pkg.sv]
package mfwt_pkg;

    // Request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Register indexes, taken from paddr[2]
    localparam int         CFG_AW      = 3;
    localparam logic       REG_MODULUS = 1'b0;
    localparam logic       REG_ACTIVE  = 1'b1;

    localparam int          VAL_W = 30;
    localparam int          POS_W = 11;
    localparam int          IDX_W = POS_W + 1;   // upward walk may step past 2047
    localparam logic [29:0] MODULUS_RESET = 30'd998244353;
    localparam logic [10:0] ACTIVE_RESET  = 11'd1024;

    // a + b in 31 bits, one conditional subtract of m, low 30 bits kept
    function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b,
                                                 input logic [VAL_W-1:0] m);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

[sv/modular_fenwick_tree.sv]
// Binary indexed tree of residues modulo a programmable modulus, one entry per
// word of a single-port-write / single-port-read RAM. A request is taken when
// start is high and busy is low; busy stays high until the request is done.
// Each tree entry visited takes a RAM read, then an update or accumulate
// step. An add visits each entry on its upward walk, and a query one entry
// per set bit of its position, each at least one. An add that is ignored and
// the unused request code also pass through one read and one update step.
// A clear request sweeps the RAM one entry per cycle. After reset the same
// sweep runs with busy high; register writes are taken meanwhile. A query
// result appears on o_prefix_sum, marked by o_result_strobe for exactly one
// cycle, in the first cycle with busy low after the query; the receiver
// cannot stall it, so it must take it in that cycle.
// Add and clear requests give no result. Registers on the APB-style port:
// 0x0 modulus (30 bits, reset 998244353), 0x4 active size (11 bits, reset
// 1024); the upward walk stops past min(active size, TREE_SIZE). Write the
// registers only while busy is low.
module modular_fenwick_tree
    import mfwt_pkg::*;
#(
    parameter int TREE_SIZE = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_req_type,
    input  logic [POS_W-1:0]  i_position,
    input  logic [VAL_W-1:0]  i_addend,
    // result side
    output logic              o_result_strobe,
    output logic [VAL_W-1:0]  o_prefix_sum,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = $clog2(TREE_SIZE);
    // indexes never exceed 12 bits, so cap the size compare there
    localparam int              CAP_INT  = (TREE_SIZE < 4095) ? TREE_SIZE : 4095;
    localparam logic [IDX_W-1:0] SIZE_CAP = IDX_W'(CAP_INT);
    localparam logic [AW-1:0]    LAST     = AW'(TREE_SIZE - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_UPD   = 4'b0100,
        S_CLEAR = 4'b1000
    } t_state;

    // control
    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_strobe, n_strobe;
    logic [VAL_W-1:0]   r_modulus;
    logic [POS_W-1:0]   r_active_size;
    // payload
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic [VAL_W-1:0]   r_prefix_sum, n_prefix_sum;
    logic [1:0]         r_req, n_req;
    logic [VAL_W-1:0]   r_addend, n_addend;

    // RAM port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [VAL_W-1:0]   ram_wdata, ram_rdata;

    // walk datapath
    logic [AW-1:0]      cur_addr;
    logic [IDX_W-1:0]   low_bit, up_idx, dn_idx, limit;
    logic               cur_ok, up_ok;
    logic [VAL_W-1:0]   entry, upd_val, q_sum;
    logic               cfg_wr;

    mfwt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TREE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus     <= MODULUS_RESET;
            r_active_size <= ACTIVE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MODULUS: r_modulus     <= pwdata[VAL_W-1:0];
                REG_ACTIVE:  r_active_size <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MODULUS: prdata = {{(32-VAL_W){1'b0}}, r_modulus};
            REG_ACTIVE:  prdata = {{(32-POS_W){1'b0}}, r_active_size};
            default:     prdata = '0;
        endcase
    end

    // ---------------- walk datapath ----------------
    // RAM word k holds tree entry k+1
    assign cur_addr = AW'(r_idx - IDX_W'(1));
    assign low_bit  = r_idx & (~r_idx + IDX_W'(1));
    assign up_idx   = r_idx + low_bit;
    assign dn_idx   = r_idx - low_bit;

    // add walk limit is min(active size, TREE_SIZE)
    assign limit  = ({1'b0, r_active_size} < SIZE_CAP) ? {1'b0, r_active_size} : SIZE_CAP;
    assign cur_ok = (r_idx != '0) && (r_idx <= limit);
    assign up_ok  = (up_idx != '0) && (up_idx <= limit);

    // query: entries above the store read as zero, index zero too
    assign entry   = ((r_idx != '0) && (r_idx <= SIZE_CAP)) ? ram_rdata : '0;
    assign upd_val = mod_add(ram_rdata, r_addend, r_modulus);
    assign q_sum   = mod_add(r_acc, entry, r_modulus);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_strobe     = 1'b0;
        n_idx        = r_idx;
        n_acc        = r_acc;
        n_prefix_sum = r_prefix_sum;
        n_req        = r_req;
        n_addend     = r_addend;
        ram_we       = 1'b0;
        ram_waddr    = cur_addr;
        ram_wdata    = upd_val;
        ram_raddr    = cur_addr;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req_type == REQ_CLEAR) begin
                        n_clr   = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_idx    = {1'b0, i_position};
                        n_acc    = '0;
                        n_req    = i_req_type;
                        n_addend = i_addend;
                        n_state  = S_READ;
                    end
                end
            end
            S_READ: begin
                // read of entry r_idx issued here, data back next cycle
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_IDLE;
                if (r_req == REQ_ADD) begin
                    if (cur_ok) begin
                        ram_we = 1'b1;
                        if (up_ok) begin
                            n_idx   = up_idx;
                            n_state = S_READ;
                        end
                    end
                end else if (r_req == REQ_QUERY) begin
                    n_acc = q_sum;
                    if (dn_idx != '0) begin
                        n_idx   = dn_idx;
                        n_state = S_READ;
                    end else begin
                        n_strobe     = 1'b1;
                        n_prefix_sum = q_sum;
                    end
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;   // zero the store after reset
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_acc        <= n_acc;
        r_prefix_sum <= n_prefix_sum;
        r_req        <= n_req;
        r_addend     <= n_addend;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_prefix_sum    = r_prefix_sum;

endmodule

[sv/mfwt_ram.sv]
module mfwt_ram #(
    parameter  int WIDTH = 30,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mfwt_checker.sv]
`include "assert_macros.svh"

module mfwt_checker
    import mfwt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       i_req_type,
    input logic [POS_W-1:0] i_position,
    input logic             o_result_strobe,
    input logic [VAL_W-1:0] o_prefix_sum
);

    // a result only ever closes out work the block was busy with
    `ASSERT_IMPLIES(a_strobe_after_busy, i_clk, i_rst_n, o_result_strobe, $past(busy), "result strobe without preceding busy")

    // an accepted request always occupies the block
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted request did not raise busy")

    // results are single-cycle pulses
    `ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_result_strobe, !o_result_strobe, "result strobe held longer than one cycle")

    // query at index zero: one RAM pass, then a zero sum
    `ASSERT_IMPLIES(a_query_zero, i_clk, i_rst_n, start && !busy && (i_req_type == REQ_QUERY) && (i_position == '0), ##3 (o_result_strobe && (o_prefix_sum == '0)), "query at index zero gave wrong result")

endmodule

bind modular_fenwick_tree mfwt_checker u_mfwt_checker (.*);
